// File: rtl/pbd_pkg.sv
package pbd_pkg;

    localparam int DATA_W    = 8;
    localparam int POS_W     = 10;
    localparam int LEN_W     = 8;
    localparam int ROW_W     = 11;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd320;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd200;

    // parser phase codes
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_REPEAT  = 2'd1;
    localparam logic [1:0] PH_LITERAL = 2'd2;

    localparam logic [DATA_W-1:0] REPEAT_MIN  = 8'd129;
    localparam logic [DATA_W:0]   REPEAT_BASE = 9'd257;
    localparam logic [ROW_W-1:0]  ROW_MAX     = 11'd2047;

    typedef struct packed {
        logic [1:0]       phase;
        logic [LEN_W-1:0] literal_left;
        logic             run_clipped;
    } t_parse;

    typedef struct packed {
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [DATA_W-1:0] pixel_value;
        logic [LEN_W-1:0]  span_length;
    } t_span;

endpackage

// File: rtl/pbd_ifs.sv
interface pbd_byte_if;
    logic                      valid;
    logic                      ready;
    logic [pbd_pkg::DATA_W-1:0] data_byte;
    logic                      image_start;

    modport source (output valid, output data_byte, output image_start, input ready);
    modport sink   (input valid, input data_byte, input image_start, output ready);
endinterface

interface pbd_span_if;
    logic                       valid;
    logic                       ready;
    logic [pbd_pkg::POS_W-1:0]  pos_x;
    logic [pbd_pkg::POS_W-1:0]  pos_y;
    logic [pbd_pkg::DATA_W-1:0] pixel_value;
    logic [pbd_pkg::LEN_W-1:0]  span_length;

    modport source (output valid, output pos_x, output pos_y, output pixel_value,
                    output span_length, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pixel_value,
                    input span_length, output ready);
endinterface

interface pbd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pbd_pkg::CFG_IDX_W-1:0] index;
    logic [pbd_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/pbd_step.sv
module pbd_step #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int COL_W      = 11
) (
    input  logic [pbd_pkg::DATA_W-1:0] i_data_byte,
    input  logic                       i_image_start,
    input  pbd_pkg::t_parse            i_parse,
    input  logic [COL_W-1:0]           i_column,
    input  logic [pbd_pkg::ROW_W-1:0]  i_row,
    input  logic [pbd_pkg::CFG_W-1:0]  i_cfg_width,
    input  logic [pbd_pkg::CFG_W-1:0]  i_cfg_height,
    output pbd_pkg::t_parse            o_parse,
    output logic [COL_W-1:0]           o_column,
    output logic [pbd_pkg::ROW_W-1:0]  o_row,
    output logic                       o_span_valid,
    output pbd_pkg::t_span             o_span
);
    import pbd_pkg::*;

    localparam int LW = (COL_W > LEN_W) ? COL_W : LEN_W;

    function automatic logic [ROW_W-1:0] row_step(input logic [ROW_W-1:0] r);
        row_step = (r == ROW_MAX) ? r : r + 1'b1;
    endfunction

    logic [COL_W-1:0] w_eff;
    logic [CFG_W-1:0] h_eff;
    t_parse           par0;
    logic [COL_W-1:0] col0, col1, col_sum, room;
    logic [ROW_W-1:0] row0, row1;
    logic [LW-1:0]    lit_ext, room_ext, len;
    logic [LEN_W-1:0] lit_dec;
    logic             emit_ok;

    // effective geometry: width clamped to 1..MAX_WIDTH, height limited to MAX_HEIGHT
    always_comb begin
        if (i_cfg_width == '0) begin
            w_eff = COL_W'(1);
        end else if (32'(i_cfg_width) > 32'(MAX_WIDTH)) begin
            w_eff = COL_W'(MAX_WIDTH);
        end else begin
            w_eff = COL_W'(i_cfg_width);
        end
        if (32'(i_cfg_height) > 32'(MAX_HEIGHT)) begin
            h_eff = CFG_W'(MAX_HEIGHT);
        end else begin
            h_eff = i_cfg_height;
        end
    end

    always_comb begin
        par0 = i_parse;
        col0 = i_column;
        row0 = i_row;
        if (i_image_start) begin
            par0 = '{phase: PH_HEADER, literal_left: '0, run_clipped: 1'b0};
            col0 = '0;
            row0 = '0;
        end

        // column past a shrunk width wraps before anything else
        if (col0 >= w_eff) begin
            col1 = '0;
            row1 = row_step(row0);
        end else begin
            col1 = col0;
            row1 = row0;
        end

        room     = w_eff - col1;
        lit_ext  = LW'(par0.literal_left);
        room_ext = LW'(room);
        len      = (lit_ext > room_ext) ? room_ext : lit_ext;
        emit_ok  = row1 < h_eff;
        col_sum  = '0;
        lit_dec  = '0;

        o_parse      = par0;
        o_column     = col1;
        o_row        = row1;
        o_span_valid = 1'b0;
        o_span       = '{pos_x: POS_W'(col1), pos_y: row1[POS_W-1:0],
                         pixel_value: i_data_byte, span_length: LEN_W'(1)};

        unique case (par0.phase)
            PH_REPEAT: begin
                if (len != '0) begin
                    o_span_valid       = emit_ok;
                    o_span.span_length = LEN_W'(len);
                    col_sum            = col1 + COL_W'(len);
                    if (col_sum >= w_eff) begin
                        o_column = '0;
                        o_row    = row_step(row1);
                    end else begin
                        o_column = col_sum;
                    end
                end
                o_parse.phase        = PH_HEADER;
                o_parse.literal_left = '0;
            end
            PH_LITERAL: begin
                if (!par0.run_clipped) begin
                    o_span_valid = emit_ok;
                    col_sum      = col1 + COL_W'(1);
                    if (col_sum >= w_eff) begin
                        o_column            = '0;
                        o_row               = row_step(row1);
                        o_parse.run_clipped = 1'b1;
                    end else begin
                        o_column = col_sum;
                    end
                end
                lit_dec              = (par0.literal_left != '0) ?
                                       par0.literal_left - 1'b1 : '0;
                o_parse.literal_left = lit_dec;
                if (lit_dec == '0) begin
                    o_parse.phase       = PH_HEADER;
                    o_parse.run_clipped = 1'b0;
                end
            end
            default: begin
                // header byte; the unused code behaves the same
                if (i_data_byte >= REPEAT_MIN) begin
                    o_parse.literal_left = LEN_W'(REPEAT_BASE - {1'b0, i_data_byte});
                    o_parse.phase        = PH_REPEAT;
                end else begin
                    o_parse.literal_left = i_data_byte + 1'b1;
                    o_parse.phase        = PH_LITERAL;
                end
                o_parse.run_clipped = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/packbits_row_clipped_image_decoder_top.sv
// packbits row-clipped image decoder
//
// i_byte  : compressed stream, one byte per beat; image_start on a beat clears
//           position and parser before that byte is parsed
// o_span  : span writes (pos_x, pos_y, pixel_value, span_length); a repeat gives
//           one span, every literal byte a span of one pixel, runs clipped at the
//           row end, spans on rows at or past the image height are dropped
// i_cfg   : register writes, index 0 image_width, index 1 image_height; always
//           ready, only meant to be written while no byte is in flight
//
// throughput is one byte per cycle unless o_span stalls; the parser state
// updates in a single pass of combinational logic between the input register
// and the span register, which a byte passes in that order on its way to o_span
// a stalled o_span holds the span register; an empty input register still takes
// one more byte, then i_byte.ready drops until the span is taken
// reset (synchronous, active low) empties both registers, clears the parser and
// position and loads width 320, height 200
module packbits_row_clipped_image_decoder_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pbd_byte_if.sink      i_byte,
    pbd_span_if.source    o_span,
    pbd_cfg_if.sink       i_cfg
);
    import pbd_pkg::*;

    // column must hold values up to the widest row
    localparam int COL_W = $clog2(MAX_WIDTH + 1);

    // configuration registers
    logic [CFG_W-1:0] r_cfg_width;
    logic [CFG_W-1:0] r_cfg_height;

    // input register
    logic              r_in_vld;
    logic [DATA_W-1:0] r_in_byte;
    logic              r_in_start;

    // parser and raster position
    t_parse           r_parse, n_parse;
    logic [COL_W-1:0] r_column, n_column;
    logic [ROW_W-1:0] r_row, n_row;

    // span register
    logic  r_out_vld;
    t_span r_span, n_span;
    logic  n_span_vld;

    logic advance;

    // span register free or draining this cycle
    assign advance      = !r_out_vld || o_span.ready;
    assign i_byte.ready = !r_in_vld || advance;
    assign i_cfg.ready  = 1'b1;

    assign o_span.valid       = r_out_vld;
    assign o_span.pos_x       = r_span.pos_x;
    assign o_span.pos_y       = r_span.pos_y;
    assign o_span.pixel_value = r_span.pixel_value;
    assign o_span.span_length = r_span.span_length;

    pbd_step #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_W      (COL_W)
    ) u_step (
        .i_data_byte   (r_in_byte),
        .i_image_start (r_in_start),
        .i_parse       (r_parse),
        .i_column      (r_column),
        .i_row         (r_row),
        .i_cfg_width   (r_cfg_width),
        .i_cfg_height  (r_cfg_height),
        .o_parse       (n_parse),
        .o_column      (n_column),
        .o_row         (n_row),
        .o_span_valid  (n_span_vld),
        .o_span        (n_span)
    );

    // configuration writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RESET;
            r_cfg_height <= HEIGHT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg.data;
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // input register: take a beat whenever the slot is free or moving on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_vld <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte  <= i_byte.data_byte;
            r_in_start <= i_byte.image_start;
        end
    end

    // parser state advances once per byte as it leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse  <= '{phase: PH_HEADER, literal_left: '0, run_clipped: 1'b0};
            r_column <= '0;
            r_row    <= '0;
        end else if (r_in_vld && advance) begin
            r_parse  <= n_parse;
            r_column <= n_column;
            r_row    <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld && n_span_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_vld && n_span_vld) begin
            r_span <= n_span;
        end
    end

    // a span always covers 1..128 pixels
    a_span_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_span.span_length != '0 && r_span.span_length <= LEN_W'(128)))
        else $error("span length out of range");

    // a held byte with a stalled span register blocks the input
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !o_span.ready) |-> !i_byte.ready)
        else $error("input accepted while pipeline full");

    // run counter agrees with the phase
    a_count_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_parse.phase == PH_HEADER) |-> (r_parse.literal_left == '0)) and
        ((r_parse.phase == PH_LITERAL) |-> (r_parse.literal_left != '0)) and
        ((r_parse.phase == PH_REPEAT) |-> (r_parse.literal_left >= LEN_W'(2))))
        else $error("run count inconsistent with parser phase");

endmodule
